[hdl/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared codes and types for the key/value table cell row.
// ----------------------------------------------------------------------------
package kvt_pkg;

    localparam int CAP_W = 9;
    localparam int POS_W = 8;
    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPSERT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

    typedef struct packed {
        logic capture;    // request accepted: compare keys, latch selects
        logic pick_hit;   // select the matching cell for readout
        logic pick_pos;   // select the cell at the requested position
        logic erase_en;   // shift cells at and above the hit down one place
        logic update_en;  // write value into the matching cell
        logic insert_en;  // write key/value into the first free cell
    } kvt_ctrl_t;

endpackage

[hdl/kvt_cell.sv]
// ----------------------------------------------------------------------------
// kvt_cell
// One table slot: holds a key/value pair, compares against the request key
// and takes its upper neighbor's pair when an erase closes the gap.
// ----------------------------------------------------------------------------
module kvt_cell
    import kvt_pkg::*;
#(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 64,
    parameter int CNT_W       = 9,
    parameter int IDX_W       = 8,
    parameter int CELL_INDEX  = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  kvt_ctrl_t              ctrl,
    input  logic [KEY_WIDTH-1:0]   req_key,
    input  logic [POS_W-1:0]       req_position,
    input  logic [KEY_WIDTH-1:0]   wr_key,
    input  logic [VALUE_WIDTH-1:0] wr_value,
    input  logic [CNT_W-1:0]       count,
    input  logic [IDX_W-1:0]       at_index,
    input  logic [KEY_WIDTH-1:0]   next_key,
    input  logic [VALUE_WIDTH-1:0] next_value,
    output logic [KEY_WIDTH-1:0]   cur_key,
    output logic [VALUE_WIDTH-1:0] cur_value,
    output logic                   hit,
    output logic [KEY_WIDTH-1:0]   sel_key,
    output logic [VALUE_WIDTH-1:0] sel_value
);

    localparam logic [31:0] IDX = 32'(CELL_INDEX);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   key_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   hit_reg;
    logic                   hit_next;
    logic                   sel_reg;
    logic                   sel_next;
    logic                   occupied;
    logic                   pos_match;

    assign occupied  = 32'(count) > IDX;
    assign pos_match = 32'(req_position) == IDX;

    always_comb
    begin
        hit_next = hit_reg;
        sel_next = sel_reg;
        if (ctrl.capture)
        begin
            hit_next = occupied && (key_reg == req_key);
            sel_next = (ctrl.pick_hit && hit_next) || (ctrl.pick_pos && pos_match && occupied);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            sel_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
            sel_reg <= sel_next;
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        priority if (ctrl.erase_en && (32'(at_index) <= IDX))
        begin
            key_next   = next_key;
            value_next = next_value;
        end
        else if (ctrl.insert_en && (32'(count) == IDX))
        begin
            key_next   = wr_key;
            value_next = wr_value;
        end
        else if (ctrl.update_en && hit_reg)
        begin
            value_next = wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign cur_key   = key_reg;
    assign cur_value = value_reg;
    assign hit       = hit_reg;
    assign sel_key   = sel_reg ? key_reg : '0;
    assign sel_value = sel_reg ? value_reg : '0;

endmodule

[hdl/key_value_table_unit.sv]
// ----------------------------------------------------------------------------
// key_value_table_unit
// Packed table of unique keys with values, built as a row of compare cells.
// ----------------------------------------------------------------------------
// On the accepting edge every cell compares its key with the request key
// and latches a hit/select bit; in ST_ACT, once any earlier result is
// claimed, the row acts at once (append at the fill position, value update
// at the hit, or a one-place shift of every cell at and above the hit on
// erase) and the result is loaded into the output register. No new request
// is taken while one is in ST_ACT; the row-wide action waits while an
// earlier result is still unclaimed. No clearing pass after reset.
module key_value_table_unit
    import kvt_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CAP_W-1:0]                     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [MODE_W-1:0]                    mode,
    input  logic [KEY_WIDTH-1:0]                 key,
    input  logic [VALUE_WIDTH-1:0]               value,
    input  logic [POS_W-1:0]                     position,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 ok,
    output logic [KEY_WIDTH-1:0]                 found_key,
    output logic [VALUE_WIDTH-1:0]               found_value,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]     entry_count,
    output logic                                 is_empty
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ACT  = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [MODE_W-1:0]      mode_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [POS_W-1:0]       position_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CAP_W-1:0]       capacity_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   ok_reg, ok_next;
    logic [KEY_WIDTH-1:0]   fkey_reg, fkey_next;
    logic [VALUE_WIDTH-1:0] fvalue_reg, fvalue_next;
    logic [CNT_W-1:0]       ocount_reg;
    logic                   empty_reg;

    kvt_ctrl_t              ctrl;
    logic                   accept;
    logic                   advance;
    logic                   present;
    logic                   found;
    logic                   can_insert;
    logic [IDX_W-1:0]       at_index;
    logic [KEY_WIDTH-1:0]   or_key;
    logic [VALUE_WIDTH-1:0] or_value;

    logic [KEY_WIDTH-1:0]   cell_key   [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] cell_value [MAX_ENTRIES];
    logic [KEY_WIDTH-1:0]   cell_skey  [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] cell_svalue[MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_hit;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign advance   = (state_reg == ST_ACT) && (!out_valid_reg || out_ready);

    // keys are unique, so at most one hit: plain OR reductions
    always_comb
    begin
        at_index = '0;
        or_key   = '0;
        or_value = '0;
        found    = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cell_hit[i])
            begin
                at_index = at_index | IDX_W'(i);
            end
            or_key   = or_key | cell_skey[i];
            or_value = or_value | cell_svalue[i];
        end
        found = (mode_reg == MODE_READ) && (32'(position_reg) < 32'(count_reg));
    end

    assign present    = |cell_hit;
    assign can_insert = (32'(count_reg) < 32'(capacity_reg))
                     && (32'(count_reg) < 32'(MAX_ENTRIES));

    always_comb
    begin
        ctrl           = '0;
        ctrl.capture   = accept;
        ctrl.pick_hit  = (mode == MODE_LOOKUP);
        ctrl.pick_pos  = (mode == MODE_READ);
        ctrl.erase_en  = advance && (mode_reg == MODE_ERASE) && present;
        ctrl.update_en = advance && present
                      && ((mode_reg == MODE_UPDATE) || (mode_reg == MODE_UPSERT));
        ctrl.insert_en = advance && !present && can_insert
                      && ((mode_reg == MODE_INSERT) || (mode_reg == MODE_UPSERT));
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            logic [KEY_WIDTH-1:0]   nkey;
            logic [VALUE_WIDTH-1:0] nvalue;
            if (g == MAX_ENTRIES - 1)
            begin : g_top
                assign nkey   = '0;
                assign nvalue = '0;
            end
            else
            begin : g_mid
                assign nkey   = cell_key[g+1];
                assign nvalue = cell_value[g+1];
            end

            kvt_cell #(
                .KEY_WIDTH  (KEY_WIDTH),
                .VALUE_WIDTH(VALUE_WIDTH),
                .CNT_W      (CNT_W),
                .IDX_W      (IDX_W),
                .CELL_INDEX (g)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .req_key     (key),
                .req_position(position),
                .wr_key      (key_reg),
                .wr_value    (value_reg),
                .count       (count_reg),
                .at_index    (at_index),
                .next_key    (nkey),
                .next_value  (nvalue),
                .cur_key     (cell_key[g]),
                .cur_value   (cell_value[g]),
                .hit         (cell_hit[g]),
                .sel_key     (cell_skey[g]),
                .sel_value   (cell_svalue[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.erase_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (ctrl.insert_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_INSERT: ok_next = !present && can_insert;
            MODE_UPDATE: ok_next = present;
            MODE_UPSERT: ok_next = present || can_insert;
            MODE_ERASE:  ok_next = present;
            MODE_LOOKUP: ok_next = present;
            MODE_READ:   ok_next = found;
            default:     ok_next = 1'b0;
        endcase
        fkey_next   = (mode_reg == MODE_READ) ? or_key : '0;
        fvalue_next = or_value;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                if (advance)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            capacity_reg  <= CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode;
            key_reg      <= key;
            value_reg    <= value;
            position_reg <= position;
        end
        if (advance)
        begin
            ok_reg     <= ok_next;
            fkey_reg   <= fkey_next;
            fvalue_reg <= fvalue_next;
            ocount_reg <= count_next;
            empty_reg  <= (count_next == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign found_key   = fkey_reg;
    assign found_value = fvalue_reg;
    assign entry_count = ocount_reg;
    assign is_empty    = empty_reg;

endmodule

[hdl/kvt_checker.sv]
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks for the key/value table, bound to the top level.
// ----------------------------------------------------------------------------
module kvt_checker
    import kvt_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 64
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             ok,
    input logic [KEY_WIDTH-1:0]             found_key,
    input logic [VALUE_WIDTH-1:0]           found_value,
    input logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count,
    input logic                             is_empty
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(found_key)
            && $stable(found_value) && $stable(entry_count))
        else $error("result changed while stalled");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while previous one in flight");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> (found_key == '0) && (found_value == '0))
        else $error("failed request returned data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(entry_count) <= 32'(MAX_ENTRIES)))
        else $error("entry count above table size");

endmodule

bind key_value_table_unit kvt_checker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .KEY_WIDTH  (KEY_WIDTH),
    .VALUE_WIDTH(VALUE_WIDTH)
) u_kvt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .found_key  (found_key),
    .found_value(found_value),
    .entry_count(entry_count),
    .is_empty   (is_empty)
);

[test/kvt_table_checker.sv]
// ----------------------------------------------------------------------------
// kvt_table_checker
// Watches the request, result and capacity channels of the key/value table.
// Keeps its own copy of the packed table, works out the result of every
// accepted request, and compares each accepted result field by field with
// the oldest outstanding one. Reports mismatches and unexpected results.
// ----------------------------------------------------------------------------
module kvt_table_checker
    import kvt_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [CAP_W-1:0]                 cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [MODE_W-1:0]                mode,
    input  logic [KEY_WIDTH-1:0]             key,
    input  logic [VALUE_WIDTH-1:0]           value,
    input  logic [POS_W-1:0]                 position,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             ok,
    input  logic [KEY_WIDTH-1:0]             found_key,
    input  logic [VALUE_WIDTH-1:0]           found_value,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] entry_count,
    input  logic                             is_empty,
    output int unsigned                      fail_count,
    output int unsigned                      pending,
    output int unsigned                      checked,
    output int unsigned                      peak_fill
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic                   ok;
        logic [KEY_WIDTH-1:0]   fkey;
        logic [VALUE_WIDTH-1:0] fvalue;
        logic [CNT_W-1:0]       count;
        logic                   empty;
    } table_result_t;

    logic [KEY_WIDTH-1:0]   row_key   [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] row_value [MAX_ENTRIES];
    int unsigned            fill;
    logic [CAP_W-1:0]       cap_limit;
    table_result_t          awaited_results [$];
    table_result_t          want;
    table_result_t          seen;

    function automatic void store_new(input logic [KEY_WIDTH-1:0] k,
                                      input logic [VALUE_WIDTH-1:0] v);
        row_key[fill]   = k;
        row_value[fill] = v;
        fill++;
    endfunction

    function automatic table_result_t apply_to_table(input logic [MODE_W-1:0]      op,
                                                     input logic [KEY_WIDTH-1:0]   k,
                                                     input logic [VALUE_WIDTH-1:0] v,
                                                     input logic [POS_W-1:0]       p);
        table_result_t r;
        int unsigned   at;
        int unsigned   i;
        logic          present;
        logic          room;
        r  = '0;
        at = fill;
        for (i = 0; i < fill; i++)
            if (at == fill && row_key[i] == k)
                at = i;
        present = (at < fill);
        room    = (fill < cap_limit) && (fill < MAX_ENTRIES);
        case (op)
            MODE_INSERT:
                if (!present && room)
                begin
                    store_new(k, v);
                    r.ok = 1'b1;
                end
            MODE_UPDATE:
                if (present)
                begin
                    row_value[at] = v;
                    r.ok = 1'b1;
                end
            MODE_UPSERT:
                if (present)
                begin
                    row_value[at] = v;
                    r.ok = 1'b1;
                end
                else if (room)
                begin
                    store_new(k, v);
                    r.ok = 1'b1;
                end
            MODE_ERASE:
                if (present)
                begin
                    for (i = at; i + 1 < fill; i++)
                    begin
                        row_key[i]   = row_key[i + 1];
                        row_value[i] = row_value[i + 1];
                    end
                    fill--;
                    r.ok = 1'b1;
                end
            MODE_LOOKUP:
                if (present)
                begin
                    r.fvalue = row_value[at];
                    r.ok     = 1'b1;
                end
            MODE_READ:
                if (p < fill)
                begin
                    r.fkey   = row_key[p];
                    r.fvalue = row_value[p];
                    r.ok     = 1'b1;
                end
            default:
                r.ok = 1'b0;
        endcase
        r.count = CNT_W'(fill);
        r.empty = (fill == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill       = 0;
            cap_limit  = CAPACITY_RESET;
            awaited_results.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
            peak_fill  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_limit = cfg_data;

            if (out_valid && out_ready)
            begin
                seen = {ok, found_key, found_value, entry_count, is_empty};
                if (awaited_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: result with no request outstanding: ok=%0b key=%h val=%h cnt=%0d empty=%0b",
                                 seen.ok, seen.fkey, seen.fvalue, seen.count, seen.empty);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("ERROR: result %0d mismatch", checked);
                            $display("  exp ok=%0b key=%h val=%h cnt=%0d empty=%0b",
                                     want.ok, want.fkey, want.fvalue, want.count, want.empty);
                            $display("  got ok=%0b key=%h val=%h cnt=%0d empty=%0b",
                                     seen.ok, seen.fkey, seen.fvalue, seen.count, seen.empty);
                        end
                        fail_count++;
                    end
                    checked++;
                end
            end

            if (in_valid && in_ready)
            begin
                awaited_results.push_back(apply_to_table(mode, key, value, position));
                if (fill > peak_fill)
                    peak_fill = fill;
            end

            pending = awaited_results.size();
        end
    end

endmodule

[test/tb_key_value_table_unit.sv]
// ----------------------------------------------------------------------------
// tb_key_value_table_unit
// Drives requests and capacity writes into the key/value table and gives
// the verdict. A directed pass covers empty-table misses, duplicates, both
// extreme keys and values, out-of-range reads and the unused modes; random
// passes then run small, zero, oversize and undersized capacities, fill the
// table to its built size, and vary sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_key_value_table_unit;
    import kvt_pkg::*;

    localparam int MAX_ENTRIES  = 256;
    localparam int KEY_WIDTH    = 32;
    localparam int VALUE_WIDTH  = 64;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [MODE_W-1:0]      mode;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [POS_W-1:0]       position;
    logic                   out_valid;
    logic                   out_ready;
    logic                   ok;
    logic [KEY_WIDTH-1:0]   found_key;
    logic [VALUE_WIDTH-1:0] found_value;
    logic [CNT_W-1:0]       entry_count;
    logic                   is_empty;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned peak_fill;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned fresh_pct;
    int unsigned pool_limit;
    int unsigned sent_count;
    int unsigned cycle_count;
    logic [KEY_WIDTH-1:0] key_pool [$];

    key_value_table_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .key         (key),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .found_key   (found_key),
        .found_value (found_value),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    kvt_table_checker #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .key         (key),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .found_key   (found_key),
        .found_value (found_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .peak_fill   (peak_fill)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(input logic [MODE_W-1:0]      op,
                                input logic [KEY_WIDTH-1:0]   k,
                                input logic [VALUE_WIDTH-1:0] v,
                                input logic [POS_W-1:0]       p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode     <= op;
        key      <= k;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // hold off new requests until every outstanding result is back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        logic [KEY_WIDTH-1:0] k;
        if (key_pool.size() == 0 ||
            ($urandom_range(99) < fresh_pct && key_pool.size() < pool_limit))
        begin
            case ($urandom_range(63))
                0:       k = '0;
                1:       k = '1;
                default: k = $urandom;
            endcase
            key_pool.push_back(k);
        end
        else
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        return k;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_random(input int unsigned n, input int unsigned ins_pct);
        logic [MODE_W-1:0] op;
        int unsigned       lim;
        repeat (n)
        begin
            if ($urandom_range(99) < 3)
                wait_drained();
            if ($urandom_range(99) < ins_pct)
                op = $urandom_range(1) ? MODE_INSERT : MODE_UPSERT;
            else
                case ($urandom_range(19))
                    0, 1, 2, 3:      op = MODE_UPDATE;
                    4, 5, 6, 7:      op = MODE_ERASE;
                    8, 9, 10, 11, 12:  op = MODE_LOOKUP;
                    13, 14, 15, 16, 17: op = MODE_READ;
                    18:              op = MODE_SPARE_LO;
                    default:         op = MODE_SPARE_HI;
                endcase
            lim = (key_pool.size() > 254 || $urandom_range(3) == 0) ? 255 : key_pool.size() + 1;
            send_request(op, pick_key(), pick_value(), POS_W'($urandom_range(lim)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        mode          = MODE_LOOKUP;
        key           = '0;
        value         = '0;
        position      = '0;
        out_ready     = 1'b0;
        cycle_count   = 0;
        sent_count    = 0;
        send_idle_pct = 14;
        recv_idle_pct = 68;
        fresh_pct     = 50;
        pool_limit    = 4;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table: every search misses
        send_request(MODE_LOOKUP, '0, '0, '0);
        send_request(MODE_READ,   '0, '0, '0);
        send_request(MODE_ERASE,  '0, '0, '0);
        send_request(MODE_UPDATE, '0, '1, '0);
        // extreme keys and values, duplicate insert, upsert both ways
        send_request(MODE_INSERT, '0, '0, '0);
        send_request(MODE_INSERT, '1, '1, '1);
        send_request(MODE_INSERT, '0, 64'h1, '0);
        send_request(MODE_UPSERT, '1, 64'h5555_5555_5555_5555, '0);
        send_request(MODE_UPSERT, 32'h1234_5678, 64'h0123_4567_89AB_CDEF, '0);
        send_request(MODE_UPDATE, '0, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_request(MODE_LOOKUP, '0, '0, '0);
        send_request(MODE_LOOKUP, '1, '0, '0);
        // reads in and out of range
        send_request(MODE_READ, '0, '0, 8'd0);
        send_request(MODE_READ, '0, '0, 8'd1);
        send_request(MODE_READ, '0, '0, 8'd2);
        send_request(MODE_READ, '0, '0, 8'd3);
        send_request(MODE_READ, '0, '0, '1);
        // unused modes on a present key
        send_request(MODE_SPARE_LO, '0, '1, '0);
        send_request(MODE_SPARE_HI, '1, '0, '1);
        // erase from the front shifts the rest down
        send_request(MODE_ERASE,  '0, '0, '0);
        send_request(MODE_READ,   '0, '0, 8'd0);
        send_request(MODE_ERASE,  '1, '0, '0);
        send_request(MODE_ERASE,  32'h1234_5678, '0, '0);
        send_request(MODE_LOOKUP, 32'h1234_5678, '0, '0);
        send_request(MODE_READ,   '0, '0, 8'd0);

        write_capacity(9'd0);
        run_random(10, 50);
        write_capacity(9'd1);
        run_random(12, 50);

        write_capacity(9'd5);
        key_pool.delete();
        pool_limit = 8;
        fresh_pct  = 30;
        run_random(60, 40);

        // oversize capacity: table fills to its built size, then inserts fail
        write_capacity(9'd511);
        send_idle_pct = 68;
        recv_idle_pct = 14;
        pool_limit    = 100000;
        fresh_pct     = 95;
        run_random(340, 94);

        // capacity now far below the entry count
        write_capacity(9'd3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fresh_pct     = 10;
        run_random(50, 20);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Summary: %0d requests sent, %0d results checked, table peaked at %0d entries",
                 sent_count, checked, peak_fill);
        $display("Capacities 256, 0, 1, 5, 511 and 3 run under three stall patterns");
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hdl/kvt_pkg.sv
hdl/kvt_cell.sv
hdl/key_value_table_unit.sv
hdl/kvt_checker.sv
test/kvt_table_checker.sv
test/tb_key_value_table_unit.sv
